FILE: design/ast_pkg.sv
package ast_pkg;

    // sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_AXIS,
        ST_DIV,
        ST_DONE
    } t_state;

    // operation codes of an input word
    localparam logic OP_SAMPLE = 1'b0;
    localparam logic OP_READ   = 1'b1;

    // stored class codes per axis
    localparam logic [1:0] CLS_ZERO = 2'b00;
    localparam logic [1:0] CLS_POS  = 2'b01;
    localparam logic [1:0] CLS_NEG  = 2'b11;

    localparam int          NUM_AXES   = 3;
    localparam int          AXIS_W     = 2;
    localparam int          RAW_W      = 16;
    localparam int          THR_W      = 9;
    localparam logic [8:0]  THR_RESET  = 9'd20;
    localparam int          ACC_W      = 32;
    localparam int          DIV_CNT_W  = 5;
    localparam int          INTENS_W   = 8;
    localparam int          STEPS_W    = 16;

endpackage

FILE: design/ast_in_if.sv
interface ast_in_if;
    logic        valid;
    logic        ready;
    logic        op;
    logic [15:0] x_raw;
    logic [15:0] y_raw;
    logic [15:0] z_raw;

    modport source (output valid, output op, output x_raw, output y_raw, output z_raw,
                    input ready);
    modport sink   (input valid, input op, input x_raw, input y_raw, input z_raw,
                    output ready);
endinterface

FILE: design/ast_out_if.sv
interface ast_out_if;
    logic        valid;
    logic        ready;
    logic [7:0]  intensity;
    logic [15:0] steps;

    modport source (output valid, output intensity, output steps, input ready);
    modport sink   (input valid, input intensity, input steps, output ready);
endinterface

FILE: design/accel_step_and_activity_tracker_top.sv
// Step and activity tracker for three-axis accelerometer words.
// Input channel i_in carries op plus three signed 16-bit raw axis words.
// op sample: the words are shifted right by SHIFT, the absolute change per
//   axis is added to a saturating sum, and each axis is classed against
//   +/- step threshold; a new nonzero class on any axis counts one step.
//   No word comes out. One shared subtract/compare unit handles one axis a
//   cycle, so a sample is accepted and then runs three axis steps.
// op read: one word goes out on o_out with intensity = sum / sample count
//   (saturated to 255, 0 when no samples) and the step count; sum, count and
//   steps are cleared. The mean comes from a 32-bit restoring divider, one
//   quotient bit a cycle: a read is accepted, runs 32 divide steps, then loads
//   the output word, waiting if the previous output word is not yet taken.
// i_in.ready is high only while the sequencer is idle; one word at a time.
// The output word sits in a register: while the receiver stalls, new samples
// are still accepted, and a following read waits in its last step.
// i_cfg_we / i_cfg_wdata write the 9-bit step threshold; write only while idle.
// Synchronous active-low reset: threshold 20, all history, sums, counters and
// classes cleared, no output word pending.
module accel_step_and_activity_tracker_top #(
    parameter int SHIFT = 6
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [ast_pkg::THR_W-1:0]   i_cfg_wdata,
    ast_in_if.sink                      i_in,
    ast_out_if.source                   o_out
);

    localparam int VW = ast_pkg::RAW_W - SHIFT;

    ast_pkg::t_state r_state, n_state;

    logic [ast_pkg::THR_W-1:0]     r_thr;
    logic [VW-1:0]                 r_prev [ast_pkg::NUM_AXES];
    logic [VW-1:0]                 n_prev [ast_pkg::NUM_AXES];
    logic [1:0]                    r_cls  [ast_pkg::NUM_AXES];
    logic [1:0]                    n_cls  [ast_pkg::NUM_AXES];
    logic [ast_pkg::ACC_W-1:0]     r_sum, n_sum;
    logic [ast_pkg::ACC_W-1:0]     r_count, n_count;
    logic [ast_pkg::STEPS_W-1:0]   r_steps, n_steps;
    logic                          r_step_seen, n_step_seen;
    logic [ast_pkg::AXIS_W-1:0]    r_axis, n_axis;
    logic [ast_pkg::RAW_W-1:0]     r_raw  [ast_pkg::NUM_AXES];
    logic [ast_pkg::RAW_W-1:0]     n_raw  [ast_pkg::NUM_AXES];

    // divider state
    logic [ast_pkg::ACC_W-1:0]     r_quo, n_quo;
    logic [ast_pkg::ACC_W-1:0]     r_rem, n_rem;
    logic [ast_pkg::ACC_W-1:0]     r_div, n_div;
    logic [ast_pkg::DIV_CNT_W-1:0] r_div_cnt, n_div_cnt;
    logic [ast_pkg::STEPS_W-1:0]   r_steps_hold, n_steps_hold;

    // output word
    logic                          r_out_valid, n_out_valid;
    logic [ast_pkg::INTENS_W-1:0]  r_intensity, n_intensity;
    logic [ast_pkg::STEPS_W-1:0]   r_out_steps, n_out_steps;

    // shared axis unit signals
    logic [ast_pkg::RAW_W-1:0]     w_raw_sel;
    logic signed [ast_pkg::RAW_W-1:0] w_shifted;
    logic signed [VW-1:0]          w_v;
    logic signed [VW-1:0]          w_p;
    logic signed [VW:0]            w_diff;
    logic [VW:0]                   w_abs;
    logic [ast_pkg::ACC_W:0]       w_sum_add;
    logic signed [16:0]            w_v_ext;
    logic signed [16:0]            w_thr_pos;
    logic signed [16:0]            w_thr_neg;
    logic [1:0]                    w_cls_new;
    logic                          w_step_axis;
    logic [ast_pkg::ACC_W:0]       w_count_add;

    // divider step signals
    logic [ast_pkg::ACC_W:0]       w_rem_shift;
    logic [ast_pkg::ACC_W+1:0]     w_rem_sub;

    logic                          w_in_acc;

    assign w_in_acc    = i_in.valid & i_in.ready;
    assign i_in.ready  = (r_state == ast_pkg::ST_IDLE);
    assign o_out.valid = r_out_valid;
    assign o_out.intensity = r_intensity;
    assign o_out.steps     = r_out_steps;

    // shared axis unit: shift, absolute change, class
    always_comb begin
        case (r_axis)
            2'd0:    w_raw_sel = r_raw[0];
            2'd1:    w_raw_sel = r_raw[1];
            default: w_raw_sel = r_raw[2];
        endcase
        w_shifted   = $signed(w_raw_sel) >>> SHIFT;
        w_v         = w_shifted[VW-1:0];
        case (r_axis)
            2'd0:    w_p = r_prev[0];
            2'd1:    w_p = r_prev[1];
            default: w_p = r_prev[2];
        endcase
        w_diff      = $signed({w_p[VW-1], w_p}) - $signed({w_v[VW-1], w_v});
        w_abs       = w_diff[VW] ? (VW+1)'(-w_diff) : w_diff;
        w_sum_add   = {1'b0, r_sum} + (ast_pkg::ACC_W+1)'(w_abs);
        w_v_ext     = 17'(w_v);
        w_thr_pos   = $signed({8'd0, r_thr});
        w_thr_neg   = -w_thr_pos;
        if (w_v_ext < w_thr_neg) begin
            w_cls_new = ast_pkg::CLS_NEG;
        end else if (w_v_ext > w_thr_pos) begin
            w_cls_new = ast_pkg::CLS_POS;
        end else begin
            w_cls_new = ast_pkg::CLS_ZERO;
        end
        case (r_axis)
            2'd0:    w_step_axis = (w_cls_new != ast_pkg::CLS_ZERO) && (w_cls_new != r_cls[0]);
            2'd1:    w_step_axis = (w_cls_new != ast_pkg::CLS_ZERO) && (w_cls_new != r_cls[1]);
            default: w_step_axis = (w_cls_new != ast_pkg::CLS_ZERO) && (w_cls_new != r_cls[2]);
        endcase
        w_count_add = {1'b0, r_count} + (ast_pkg::ACC_W+1)'(1);
    end

    // restoring divider step
    always_comb begin
        w_rem_shift = {r_rem, r_quo[ast_pkg::ACC_W-1]};
        w_rem_sub   = {1'b0, w_rem_shift} - {2'b00, r_div};
    end

    // next state and datapath
    always_comb begin
        n_state      = r_state;
        n_prev       = r_prev;
        n_cls        = r_cls;
        n_sum        = r_sum;
        n_count      = r_count;
        n_steps      = r_steps;
        n_step_seen  = r_step_seen;
        n_axis       = r_axis;
        n_raw        = r_raw;
        n_quo        = r_quo;
        n_rem        = r_rem;
        n_div        = r_div;
        n_div_cnt    = r_div_cnt;
        n_steps_hold = r_steps_hold;
        n_out_valid  = r_out_valid & ~o_out.ready;
        n_intensity  = r_intensity;
        n_out_steps  = r_out_steps;

        case (r_state)
            ast_pkg::ST_IDLE: begin
                if (w_in_acc) begin
                    if (i_in.op == ast_pkg::OP_READ) begin
                        n_quo        = r_sum;
                        n_rem        = '0;
                        n_div        = r_count;
                        n_div_cnt    = '0;
                        n_steps_hold = r_steps;
                        n_sum        = '0;
                        n_count      = '0;
                        n_steps      = '0;
                        n_state      = ast_pkg::ST_DIV;
                    end else begin
                        n_raw[0]    = i_in.x_raw;
                        n_raw[1]    = i_in.y_raw;
                        n_raw[2]    = i_in.z_raw;
                        n_axis      = '0;
                        n_step_seen = 1'b0;
                        n_state     = ast_pkg::ST_AXIS;
                    end
                end
            end
            ast_pkg::ST_AXIS: begin
                n_sum = w_sum_add[ast_pkg::ACC_W] ? '1 : w_sum_add[ast_pkg::ACC_W-1:0];
                case (r_axis)
                    2'd0: begin
                        n_prev[0] = w_v;
                        if (w_step_axis) begin
                            n_cls[0] = w_cls_new;
                        end
                    end
                    2'd1: begin
                        n_prev[1] = w_v;
                        if (w_step_axis) begin
                            n_cls[1] = w_cls_new;
                        end
                    end
                    default: begin
                        n_prev[2] = w_v;
                        if (w_step_axis) begin
                            n_cls[2] = w_cls_new;
                        end
                    end
                endcase
                n_step_seen = r_step_seen | w_step_axis;
                if (r_axis == 2'd2) begin
                    n_count = w_count_add[ast_pkg::ACC_W] ? '1
                                                          : w_count_add[ast_pkg::ACC_W-1:0];
                    if ((r_step_seen | w_step_axis) && (r_steps != '1)) begin
                        n_steps = r_steps + 1'b1;
                    end
                    n_state = ast_pkg::ST_IDLE;
                end else begin
                    n_axis = r_axis + 1'b1;
                end
            end
            ast_pkg::ST_DIV: begin
                if (w_rem_sub[ast_pkg::ACC_W+1]) begin
                    n_rem = w_rem_shift[ast_pkg::ACC_W-1:0];
                    n_quo = {r_quo[ast_pkg::ACC_W-2:0], 1'b0};
                end else begin
                    n_rem = w_rem_sub[ast_pkg::ACC_W-1:0];
                    n_quo = {r_quo[ast_pkg::ACC_W-2:0], 1'b1};
                end
                n_div_cnt = r_div_cnt + 1'b1;
                if (r_div_cnt == '1) begin
                    n_state = ast_pkg::ST_DONE;
                end
            end
            ast_pkg::ST_DONE: begin
                // wait until the output register is free
                if (!r_out_valid || o_out.ready) begin
                    n_out_valid = 1'b1;
                    n_out_steps = r_steps_hold;
                    if (r_div == '0) begin
                        n_intensity = '0;
                    end else if (r_quo[ast_pkg::ACC_W-1:ast_pkg::INTENS_W] != '0) begin
                        n_intensity = '1;
                    end else begin
                        n_intensity = r_quo[ast_pkg::INTENS_W-1:0];
                    end
                    n_state = ast_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = ast_pkg::ST_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ast_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // control and tracking state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr       <= ast_pkg::THR_RESET;
            for (int i = 0; i < ast_pkg::NUM_AXES; i++) begin
                r_prev[i] <= '0;
                r_cls[i]  <= ast_pkg::CLS_ZERO;
            end
            r_sum       <= '0;
            r_count     <= '0;
            r_steps     <= '0;
            r_step_seen <= 1'b0;
            r_axis      <= '0;
            r_div_cnt   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_thr <= i_cfg_wdata;
            end
            r_prev      <= n_prev;
            r_cls       <= n_cls;
            r_sum       <= n_sum;
            r_count     <= n_count;
            r_steps     <= n_steps;
            r_step_seen <= n_step_seen;
            r_axis      <= n_axis;
            r_div_cnt   <= n_div_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_raw        <= n_raw;
        r_quo        <= n_quo;
        r_rem        <= n_rem;
        r_div        <= n_div;
        r_steps_hold <= n_steps_hold;
        r_intensity  <= n_intensity;
        r_out_steps  <= n_out_steps;
    end

endmodule
